// ===== src/segment_interval_profiler_unit_defines.svh =====
// Assertion macros used by the profiler top level.
`ifndef SEGMENT_INTERVAL_PROFILER_UNIT_DEFINES_SVH
`define SEGMENT_INTERVAL_PROFILER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/segip_pkg.sv =====
package segip_pkg;

  localparam int DEFAULT_MAX_MARKS = 64;

  localparam int OP_W   = 3;
  localparam int TS_W   = 32;
  localparam int FC_W   = 32;
  localparam int ST_W   = 3;
  localparam int TICK_W = 32;
  localparam int SUM_W  = 64;
  localparam int CNT_W  = 32;

  localparam logic [OP_W-1:0] OP_START  = 3'd0;
  localparam logic [OP_W-1:0] OP_MARK   = 3'd1;
  localparam logic [OP_W-1:0] OP_FRAME  = 3'd2;
  localparam logic [OP_W-1:0] OP_FACETS = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd1;
  localparam logic [ST_W-1:0] ST_MISMATCH = 3'd2;
  localparam logic [ST_W-1:0] ST_DISABLED = 3'd3;
  localparam logic [ST_W-1:0] ST_BADINDEX = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0]  sample_count;
    logic [SUM_W-1:0]  sum_sq_ticks;
    logic [SUM_W-1:0]  sum_ticks;
    logic [TICK_W-1:0] max_ticks;
    logic [TICK_W-1:0] min_ticks;
  } seg_stats_t;

  localparam int STATS_W    = $bits(seg_stats_t);
  localparam int OUT_DATA_W = STATS_W + FC_W;

  localparam seg_stats_t STATS_INIT = '{
    sample_count: '0,
    sum_sq_ticks: '0,
    sum_ticks:    '0,
    max_ticks:    '0,
    min_ticks:    '1
  };

  typedef struct packed {
    logic capture;
    logic exec;
    logic mark_rd;
    logic step;
    logic square;
    logic update;
    logic load_out;
  } segip_cmd_t;

  typedef struct packed {
    logic walk_req;
    logic walk_last;
    logic out_free;
  } segip_sts_t;

endpackage

// ===== src/segip_ctrl.sv =====
module segip_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  segip_pkg::segip_sts_t sts,
  output segip_pkg::segip_cmd_t cmd
);
  import segip_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MARK_RD,
    S_DELTA,
    S_SQUARE,
    S_UPDATE,
    S_RESP
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= sts.walk_req ? S_MARK_RD : S_RESP;
        end
        S_MARK_RD: state <= S_DELTA;
        S_DELTA:   state <= S_SQUARE;
        S_SQUARE:  state <= S_UPDATE;
        S_UPDATE: begin
          state <= sts.walk_last ? S_RESP : S_MARK_RD;
        end
        S_RESP: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.exec     = (state == S_EXEC);
    cmd.mark_rd  = (state == S_MARK_RD);
    cmd.step     = (state == S_DELTA);
    cmd.square   = (state == S_SQUARE);
    cmd.update   = (state == S_UPDATE);
    cmd.load_out = (state == S_RESP) && sts.out_free;
  end

endmodule

// ===== src/segip_datapath.sv =====
module segip_datapath #(
  parameter int MAX_MARKS = segip_pkg::DEFAULT_MAX_MARKS,
  parameter int IN_DATA_W = 72
) (
  input  logic                               clk,
  input  logic                               rst,
  input  segip_pkg::segip_cmd_t              cmd,
  output segip_pkg::segip_sts_t              sts,
  input  logic [IN_DATA_W-1:0]               in_data,
  input  logic [segip_pkg::OP_W-1:0]         in_op,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [segip_pkg::ST_W-1:0]         out_status,
  output logic [segip_pkg::OUT_DATA_W-1:0]   out_data
);
  import segip_pkg::*;

  localparam int DEPTH = MAX_MARKS + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] MAX_IDX  = IDX_W'(MAX_MARKS);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_ZERO = '0;

  logic [OP_W-1:0]   op;
  logic [TS_W-1:0]   ts;
  logic [FC_W-1:0]   fc;
  logic [IDX_W-1:0]  idx;

  logic              active;
  logic [IDX_W-1:0]  next_mark;
  logic [IDX_W-1:0]  segment_total;
  logic [FC_W-1:0]   facets;
  logic [DEPTH-1:0]  row_valid;
  logic [TS_W-1:0]   frame_start;

  logic [IDX_W-1:0]  seg;
  logic [TS_W-1:0]   prev;
  logic [TICK_W-1:0] delta;
  logic [SUM_W-1:0]  sq;

  logic [TS_W-1:0]   mark_mem [DEPTH];
  logic [TS_W-1:0]   mt_rdata;
  seg_stats_t        stats_mem [DEPTH];
  seg_stats_t        st_rdata;
  logic              st_rvalid;

  logic [ST_W-1:0]   res_status;
  logic              res_read;

  logic              bad_idx;
  logic              mark_ok;
  logic              last_seg;
  logic              first_seg;
  logic [TS_W-1:0]   cur;
  logic [TS_W-1:0]   base;
  logic              st_rd_en;
  logic [IDX_W-1:0]  st_addr;
  logic [ST_W-1:0]   exec_status;
  seg_stats_t        old_stats;
  seg_stats_t        new_stats;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W:0]    sum_sq_ext;

  always_comb begin
    bad_idx   = (idx > MAX_IDX);
    mark_ok   = active && (next_mark < MAX_IDX);
    first_seg = (seg == IDX_ZERO);
    last_seg  = (seg == next_mark);
    cur       = (first_seg || last_seg) ? ts : mt_rdata;
    base      = first_seg ? frame_start : prev;
    st_rd_en  = (cmd.exec && (op == OP_READ)) || cmd.step;
    st_addr   = cmd.exec ? (bad_idx ? IDX_ZERO : idx) : seg;

    sts.walk_req  = (op == OP_FRAME) && active;
    sts.walk_last = first_seg;
    sts.out_free  = !out_valid || out_ready;

    unique case (op)
      OP_MARK: begin
        if (!active) exec_status = ST_DISABLED;
        else if (!mark_ok) exec_status = ST_OVERFLOW;
        else exec_status = ST_OK;
      end
      OP_FRAME: begin
        if (!active) exec_status = ST_DISABLED;
        else if ((segment_total != IDX_ZERO) && (segment_total != next_mark)) begin
          exec_status = ST_MISMATCH;
        end else exec_status = ST_OK;
      end
      OP_READ: exec_status = bad_idx ? ST_BADINDEX : ST_OK;
      default: exec_status = ST_OK;
    endcase

    old_stats  = st_rvalid ? st_rdata : STATS_INIT;
    sum_ext    = {1'b0, old_stats.sum_ticks} + (SUM_W+1)'(delta);
    sum_sq_ext = {1'b0, old_stats.sum_sq_ticks} + {1'b0, sq};
    new_stats.min_ticks    = (delta < old_stats.min_ticks) ? delta : old_stats.min_ticks;
    new_stats.max_ticks    = (delta > old_stats.max_ticks) ? delta : old_stats.max_ticks;
    new_stats.sum_ticks    = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    new_stats.sum_sq_ticks = sum_sq_ext[SUM_W] ? '1 : sum_sq_ext[SUM_W-1:0];
    new_stats.sample_count = old_stats.sample_count + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      next_mark     <= IDX_ONE;
      segment_total <= IDX_ZERO;
      facets        <= '0;
      row_valid     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.exec) begin
        unique case (op)
          OP_START: begin
            active        <= 1'b1;
            next_mark     <= IDX_ONE;
            segment_total <= IDX_ZERO;
            facets        <= '0;
            row_valid     <= '0;
          end
          OP_MARK: begin
            if (mark_ok) next_mark <= next_mark + IDX_ONE;
          end
          OP_FRAME: begin
            if (active && (segment_total == IDX_ZERO)) segment_total <= next_mark;
          end
          OP_FACETS: facets <= facets + fc;
          OP_STOP:   active <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.update) begin
        row_valid[seg] <= 1'b1;
        if (first_seg) next_mark <= IDX_ONE;
      end
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= in_op;
      ts  <= in_data[TS_W-1:0];
      fc  <= in_data[TS_W +: FC_W];
      idx <= in_data[TS_W+FC_W +: IDX_W];
    end
    if (cmd.exec) begin
      res_status <= exec_status;
      res_read   <= (op == OP_READ) && !bad_idx;
      seg        <= IDX_ONE;
      prev       <= frame_start;
      if (op == OP_START) frame_start <= ts;
    end
    if (cmd.step) begin
      delta <= cur - base;
      prev  <= cur;
    end
    if (cmd.square) sq <= SUM_W'(delta) * SUM_W'(delta);
    if (cmd.update) begin
      if (first_seg) begin
        frame_start <= ts;
      end else if (last_seg) begin
        seg <= IDX_ZERO;
      end else begin
        seg <= seg + IDX_ONE;
      end
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_data   <= {facets, res_read ? (st_rvalid ? st_rdata : STATS_INIT) : STATS_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (op == OP_MARK) && mark_ok) mark_mem[next_mark] <= ts;
    if (cmd.mark_rd) mt_rdata <= mark_mem[seg];
  end

  always_ff @(posedge clk) begin
    if (cmd.update) stats_mem[seg] <= new_stats;
    if (st_rd_en) begin
      st_rdata  <= stats_mem[st_addr];
      st_rvalid <= row_valid[st_addr];
    end
  end

endmodule

// ===== src/segment_interval_profiler_unit.sv =====
// Every request other than an active frame end goes through the execute and response states,
// and its result is loaded once the output is free; requests are taken one at a time, the next
// may be taken in the same cycle as the last result appears. An active frame end walks next_mark + 1
// segments in turn through the shared mark-read, delta, square and statistics-update steps.
// Reset is synchronous and leaves the unit disabled with all segment statistics cleared
// at once through per-row valid flags; there is no clearing pass.
`include "segment_interval_profiler_unit_defines.svh"

module segment_interval_profiler_unit #(
  parameter int MAX_MARKS = segip_pkg::DEFAULT_MAX_MARKS,
  localparam int IDX_W = $clog2(MAX_MARKS + 1),
  localparam int IN_BITS = segip_pkg::TS_W + segip_pkg::FC_W + IDX_W,
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // timestamp, facet_count, segment_index, zero padding
  input  logic [IN_DATA_W-1:0]             s_axis_tdata,
  // opcode
  input  logic [segip_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // min_ticks, max_ticks, sum_ticks, sum_sq_ticks, sample_count, facet_total
  output logic [segip_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [segip_pkg::ST_W-1:0]       m_axis_tuser
);
  import segip_pkg::*;

  segip_cmd_t cmd;
  segip_sts_t sts;

  segip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  segip_datapath #(
    .MAX_MARKS (MAX_MARKS),
    .IN_DATA_W (IN_DATA_W)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (s_axis_tdata),
    .in_op      (s_axis_tuser),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_data   (m_axis_tdata)
  );

  `SIP_ASSERT_SAME(a_walk_blocks_input, (cmd.step || cmd.square || cmd.update), !s_axis_tready, "request accepted during segment walk")
  `SIP_ASSERT_NEXT(a_accept_then_exec, (s_axis_tvalid && s_axis_tready), cmd.exec, "accepted request not executed")
  `SIP_ASSERT_SAME(a_load_when_free, cmd.load_out, (!m_axis_tvalid || m_axis_tready), "result overwritten before it was taken")
  `SIP_ASSERT_SAME(a_error_no_stats, (m_axis_tvalid && (m_axis_tuser != ST_OK)), (m_axis_tdata[STATS_W-1:0] == '0), "statistics reported with error status")

endmodule
